// File: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing hash table: command codes,
// slot flag codes, register indexes, reset values and the slot entry layout.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_LOAD   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] FLAG_FREE    = 2'd0;
    localparam logic [1:0] FLAG_LIVE    = 2'd1;
    localparam logic [1:0] FLAG_DELETED = 2'd2;

    localparam logic [0:0] CFG_INIT_LOG2 = 1'b0;
    localparam logic [0:0] CFG_REHASH    = 1'b1;

    localparam logic [3:0]  INIT_LOG2_RST = 4'd4;
    localparam logic [15:0] REHASH_RST    = 16'd512;

    typedef struct packed {
        logic [1:0]  flags;
        logic [31:0] hash;
        logic [31:0] key;
        logic [31:0] value;
    } slot_t;

endpackage

// File: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key-value table with open addressing, linear probing and tabulation hash,
// with tombstone delete, grow/shrink and periodic rebuild into the other bank.
//
//   channel   | signals                                         | handshake
//   ----------+-------------------------------------------------+-------------
//   request   | cmd key_hash key value word_index word_data     | start & !busy
//   result    | found value_out status live_count size_log2     | done strobe
//   config    | cfg_index cfg_data                              | cfg_we
//
// Insert, lookup and delete hash the key (one word read per nibble from the
// hash word memory), then probe slots, each read in S_PRD and checked in S_PCHK.
// Load and unknown commands go straight to done; clear first frees every slot.
// A rebuild or resize, all through the one slot port, clears every new slot,
// scans every old slot (read, check, next) and hashes and probes each live entry.
// After reset a clearing pass over the initial table size runs with busy high.
// The result is shown for one cycle with done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int MAX_LOG2    = 10,
    parameter int NIBBLE_BITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  logic [31:0]         key_hash,
    input  logic [31:0]         key,
    input  logic [31:0]         value,
    input  logic [6:0]          word_index,
    input  logic [31:0]         word_data,
    output logic                done,
    output logic                found,
    output logic [31:0]         value_out,
    output logic                status,
    output logic [MAX_LOG2:0]   live_count,
    output logic [3:0]          size_log2,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int CNT_W    = MAX_LOG2 + 1;
    localparam int HPOS     = (32 + NIBBLE_BITS - 1) / NIBBLE_BITS;
    localparam int POS_W    = $clog2(HPOS);
    localparam int HCNT_W   = $clog2(HPOS + 1);
    localparam int HW_AW    = POS_W + NIBBLE_BITS;
    localparam int HW_DEPTH = HPOS << NIBBLE_BITS;
    localparam int SLOTS    = 2 << MAX_LOG2;
    localparam int CMP_W    = 40 + MAX_LOG2;
    localparam logic [3:0] RST_LOG2 =
        (lpht_pkg::INIT_LOG2_RST < 4'(MAX_LOG2)) ? lpht_pkg::INIT_LOG2_RST : 4'(MAX_LOG2);

    typedef enum logic [3:0] {
        S_IDLE, S_COUNT, S_CLEAR, S_HASH, S_PRD, S_PCHK, S_POST,
        S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE, RET_DONE, RET_SCAN
    } ret_t;

    state_t                state_reg, state_next;
    ret_t                  clr_ret_reg, clr_ret_next;
    logic [3:0]            init_log2_reg, init_log2_next;
    logic [15:0]           rehash_reg, rehash_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [31:0]           hkey_reg, hkey_next;
    logic [31:0]           key_reg, key_next;
    logic [31:0]           val_reg, val_next;
    logic [31:0]           cur_h_reg, cur_h_next;
    logic [31:0]           cur_k_reg, cur_k_next;
    logic [31:0]           cur_v_reg, cur_v_next;
    logic [31:0]           hsh_reg, hsh_next;
    logic [31:0]           hacc_reg, hacc_next;
    logic [HCNT_W-1:0]     hcnt_reg, hcnt_next;
    logic [MAX_LOG2-1:0]   probe_idx_reg, probe_idx_next;
    logic [MAX_LOG2-1:0]   probe_cnt_reg, probe_cnt_next;
    logic [MAX_LOG2-1:0]   tgt_reg, tgt_next;
    logic                  tfree_reg, tfree_next;
    logic                  have_reg, have_next;
    logic [MAX_LOG2-1:0]   clr_idx_reg, clr_idx_next;
    logic [MAX_LOG2-1:0]   scan_idx_reg, scan_idx_next;
    logic [3:0]            old_log2_reg, old_log2_next;
    logic [3:0]            log2_reg, log2_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [31:0]           op_reg, op_next;
    logic                  bank_reg, bank_next;
    logic                  src_bank_reg, src_bank_next;
    logic                  in_rebuild_reg, in_rebuild_next;
    logic                  then_cmd_reg, then_cmd_next;
    logic                  found_reg, found_next;
    logic [31:0]           value_out_reg, value_out_next;
    logic                  status_reg, status_next;

    lpht_pkg::slot_t       slot_mem [0:SLOTS-1];
    lpht_pkg::slot_t       slot_rd_reg;
    lpht_pkg::slot_t       slot_wdata;
    logic                  slot_we;
    logic [MAX_LOG2:0]     slot_waddr;
    logic [MAX_LOG2:0]     slot_raddr;

    logic [31:0]           hash_mem [0:HW_DEPTH-1];
    logic [31:0]           hw_rd_reg;
    logic                  hw_we;
    logic [HW_AW-1:0]      hw_waddr;
    logic [HW_AW-1:0]      hw_raddr;
    logic [31:0]           widx_ext;

    logic [CNT_W-1:0]      size;
    logic [MAX_LOG2-1:0]   mask;
    logic [MAX_LOG2-1:0]   old_mask;
    logic [31:0]           hash_full;
    logic [CMP_W-1:0]      lim_lhs;
    logic [CMP_W-1:0]      lim_rhs;
    logic                  limit_hit;
    logic                  grow_hit;
    logic                  shrink_hit;
    logic                  key_match;
    logic                  last_slot;
    logic                  have_eff;
    logic [MAX_LOG2-1:0]   tgt_eff;
    logic                  tfree_eff;
    logic                  place_mode;
    logic                  probe_done;
    logic                  hash_go;
    logic [31:0]           go_h;
    logic [31:0]           go_k;
    logic [31:0]           go_v;
    logic                  rb_go;
    logic [3:0]            rb_log2;
    logic                  rb_then;

    assign size       = CNT_W'(1) << log2_reg;
    assign mask       = MAX_LOG2'(size - CNT_W'(1));
    assign old_mask   = MAX_LOG2'((CNT_W'(1) << old_log2_reg) - CNT_W'(1));
    assign hash_full  = hacc_reg ^ hw_rd_reg;
    assign lim_lhs    = CMP_W'({op_reg, 8'h00});
    assign lim_rhs    = CMP_W'(rehash_reg) << log2_reg;
    assign limit_hit  = lim_lhs > lim_rhs;
    assign grow_hit   = (used_reg > (size >> 1)) && (log2_reg < 4'(MAX_LOG2));
    assign shrink_hit = (live_reg < (size >> 3)) && (log2_reg != 4'd0);
    assign key_match  = (slot_rd_reg.hash == cur_h_reg) && (slot_rd_reg.key == cur_k_reg);
    assign last_slot  = probe_cnt_reg == mask;
    assign have_eff   = have_reg || (slot_rd_reg.flags == lpht_pkg::FLAG_FREE)
                        || (slot_rd_reg.flags == lpht_pkg::FLAG_DELETED);
    assign tgt_eff    = have_reg ? tgt_reg : probe_idx_reg;
    assign tfree_eff  = have_reg ? tfree_reg : (slot_rd_reg.flags == lpht_pkg::FLAG_FREE);
    assign place_mode = in_rebuild_reg || (cmd_reg == lpht_pkg::CMD_INSERT);
    assign widx_ext   = 32'(word_index);
    assign hw_waddr   = widx_ext[HW_AW-1:0];
    assign hw_raddr   = {hcnt_reg[POS_W-1:0], hsh_reg[NIBBLE_BITS-1:0]};
    assign slot_raddr = (state_reg == S_SCAN_RD) ? {src_bank_reg, scan_idx_reg}
                                                 : {bank_reg, probe_idx_reg};

    assign busy       = state_reg != S_IDLE;
    assign done       = state_reg == S_DONE;
    assign found      = found_reg;
    assign value_out  = value_out_reg;
    assign status     = status_reg;
    assign live_count = live_reg;
    assign size_log2  = log2_reg;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hw_we)
        begin
            hash_mem[hw_waddr] <= word_data;
        end
        hw_rd_reg <= hash_mem[hw_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_ret_next    = clr_ret_reg;
        init_log2_next  = init_log2_reg;
        rehash_next     = rehash_reg;
        cmd_next        = cmd_reg;
        hkey_next       = hkey_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cur_h_next      = cur_h_reg;
        cur_k_next      = cur_k_reg;
        cur_v_next      = cur_v_reg;
        hsh_next        = hsh_reg;
        hacc_next       = hacc_reg;
        hcnt_next       = hcnt_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        tgt_next        = tgt_reg;
        tfree_next      = tfree_reg;
        have_next       = have_reg;
        clr_idx_next    = clr_idx_reg;
        scan_idx_next   = scan_idx_reg;
        old_log2_next   = old_log2_reg;
        log2_next       = log2_reg;
        live_next       = live_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        bank_next       = bank_reg;
        src_bank_next   = src_bank_reg;
        in_rebuild_next = in_rebuild_reg;
        then_cmd_next   = then_cmd_reg;
        found_next      = found_reg;
        value_out_next  = value_out_reg;
        status_next     = status_reg;
        slot_we         = 1'b0;
        slot_waddr      = {bank_reg, probe_idx_reg};
        slot_wdata      = '0;
        hw_we           = 1'b0;
        probe_done      = 1'b0;
        hash_go         = 1'b0;
        go_h            = hkey_reg;
        go_k            = key_reg;
        go_v            = val_reg;
        rb_go           = 1'b0;
        rb_log2         = log2_reg;
        rb_then         = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                lpht_pkg::CFG_INIT_LOG2: init_log2_next = cfg_data[3:0];
                lpht_pkg::CFG_REHASH:    rehash_next    = cfg_data;
                default:                 rehash_next    = rehash_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = cmd;
                    hkey_next      = key_hash;
                    key_next       = key;
                    val_next       = value;
                    found_next     = 1'b0;
                    value_out_next = '0;
                    status_next    = 1'b0;
                    if (cmd inside {lpht_pkg::CMD_INSERT, lpht_pkg::CMD_LOOKUP,
                                    lpht_pkg::CMD_DELETE})
                    begin
                        op_next    = (op_reg == '1) ? op_reg : op_reg + 32'd1;
                        state_next = S_COUNT;
                    end
                    else if (cmd == lpht_pkg::CMD_LOAD)
                    begin
                        hw_we      = widx_ext < 32'(HW_DEPTH);
                        state_next = S_DONE;
                    end
                    else if (cmd == lpht_pkg::CMD_CLEAR)
                    begin
                        log2_next    = (init_log2_reg > 4'(MAX_LOG2)) ? 4'(MAX_LOG2)
                                                                      : init_log2_reg;
                        live_next    = '0;
                        used_next    = '0;
                        op_next      = '0;
                        clr_idx_next = '0;
                        clr_ret_next = RET_DONE;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_COUNT:
            begin
                if (limit_hit)
                begin
                    rb_go   = 1'b1;
                    rb_log2 = log2_reg;
                    rb_then = 1'b1;
                end
                else
                begin
                    hash_go = 1'b1;
                end
            end

            S_CLEAR:
            begin
                slot_we          = 1'b1;
                slot_waddr       = {bank_reg, clr_idx_reg};
                slot_wdata.flags = lpht_pkg::FLAG_FREE;
                if (clr_idx_reg == mask)
                begin
                    case (clr_ret_reg)
                        RET_IDLE: state_next = S_IDLE;
                        RET_DONE: state_next = S_DONE;
                        default:
                        begin
                            scan_idx_next = '0;
                            state_next    = S_SCAN_RD;
                        end
                    endcase
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_HASH:
            begin
                hcnt_next = hcnt_reg + 1'b1;
                hsh_next  = hsh_reg >> NIBBLE_BITS;
                if (hcnt_reg != '0)
                begin
                    hacc_next = hash_full;
                end
                if (hcnt_reg == HCNT_W'(HPOS))
                begin
                    probe_idx_next = hash_full[MAX_LOG2-1:0] & mask;
                    probe_cnt_next = '0;
                    state_next     = S_PRD;
                end
            end

            S_PRD:
            begin
                state_next = S_PCHK;
            end

            S_PCHK:
            begin
                if (place_mode)
                begin
                    if ((slot_rd_reg.flags == lpht_pkg::FLAG_LIVE) && key_match)
                    begin
                        slot_we          = 1'b1;
                        slot_wdata       = slot_rd_reg;
                        slot_wdata.value = cur_v_reg;
                        probe_done       = 1'b1;
                    end
                    else if ((slot_rd_reg.flags == lpht_pkg::FLAG_FREE) || last_slot)
                    begin
                        probe_done = 1'b1;
                        if (have_eff)
                        begin
                            slot_we    = 1'b1;
                            slot_waddr = {bank_reg, tgt_eff};
                            slot_wdata = '{flags: lpht_pkg::FLAG_LIVE, hash: cur_h_reg,
                                           key: cur_k_reg, value: cur_v_reg};
                            live_next  = live_reg + 1'b1;
                            if (tfree_eff)
                            begin
                                used_next = used_reg + 1'b1;
                            end
                        end
                        else if (!in_rebuild_reg)
                        begin
                            status_next = 1'b1;
                        end
                    end
                    else
                    begin
                        have_next  = have_eff;
                        tgt_next   = tgt_eff;
                        tfree_next = tfree_eff;
                    end
                end
                else
                begin
                    if (slot_rd_reg.flags == lpht_pkg::FLAG_FREE)
                    begin
                        probe_done = 1'b1;
                    end
                    else if ((slot_rd_reg.flags == lpht_pkg::FLAG_LIVE) && key_match)
                    begin
                        probe_done = 1'b1;
                        found_next = 1'b1;
                        if (cmd_reg == lpht_pkg::CMD_LOOKUP)
                        begin
                            value_out_next = slot_rd_reg.value;
                        end
                        else
                        begin
                            slot_we          = 1'b1;
                            slot_wdata       = slot_rd_reg;
                            slot_wdata.flags = lpht_pkg::FLAG_DELETED;
                            live_next        = live_reg - 1'b1;
                        end
                    end
                    else if (last_slot)
                    begin
                        probe_done = 1'b1;
                    end
                end

                if (probe_done)
                begin
                    state_next = in_rebuild_reg ? S_SCAN_NEXT : S_POST;
                end
                else
                begin
                    probe_idx_next = (probe_idx_reg + 1'b1) & mask;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = S_PRD;
                end
            end

            S_POST:
            begin
                if ((cmd_reg == lpht_pkg::CMD_INSERT) && grow_hit)
                begin
                    rb_go   = 1'b1;
                    rb_log2 = log2_reg + 4'd1;
                end
                else if ((cmd_reg == lpht_pkg::CMD_DELETE) && shrink_hit)
                begin
                    rb_go   = 1'b1;
                    rb_log2 = log2_reg - 4'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (slot_rd_reg.flags == lpht_pkg::FLAG_LIVE)
                begin
                    hash_go = 1'b1;
                    go_h    = slot_rd_reg.hash;
                    go_k    = slot_rd_reg.key;
                    go_v    = slot_rd_reg.value;
                end
                else
                begin
                    state_next = S_SCAN_NEXT;
                end
            end

            S_SCAN_NEXT:
            begin
                if (scan_idx_reg == old_mask)
                begin
                    in_rebuild_next = 1'b0;
                    if (then_cmd_reg)
                    begin
                        hash_go = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (hash_go)
        begin
            cur_h_next = go_h;
            cur_k_next = go_k;
            cur_v_next = go_v;
            hsh_next   = go_h;
            hcnt_next  = '0;
            hacc_next  = '0;
            have_next  = 1'b0;
            state_next = S_HASH;
        end

        if (rb_go)
        begin
            src_bank_next   = bank_reg;
            bank_next       = !bank_reg;
            old_log2_next   = log2_reg;
            log2_next       = rb_log2;
            live_next       = '0;
            used_next       = '0;
            op_next         = '0;
            in_rebuild_next = 1'b1;
            then_cmd_next   = rb_then;
            clr_idx_next    = '0;
            clr_ret_next    = RET_SCAN;
            state_next      = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_ret_reg    <= RET_IDLE;
            init_log2_reg  <= lpht_pkg::INIT_LOG2_RST;
            rehash_reg     <= lpht_pkg::REHASH_RST;
            cmd_reg        <= '0;
            hkey_reg       <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            cur_h_reg      <= '0;
            cur_k_reg      <= '0;
            cur_v_reg      <= '0;
            hsh_reg        <= '0;
            hacc_reg       <= '0;
            hcnt_reg       <= '0;
            probe_idx_reg  <= '0;
            probe_cnt_reg  <= '0;
            tgt_reg        <= '0;
            tfree_reg      <= 1'b0;
            have_reg       <= 1'b0;
            clr_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            old_log2_reg   <= '0;
            log2_reg       <= RST_LOG2;
            live_reg       <= '0;
            used_reg       <= '0;
            op_reg         <= '0;
            bank_reg       <= 1'b0;
            src_bank_reg   <= 1'b0;
            in_rebuild_reg <= 1'b0;
            then_cmd_reg   <= 1'b0;
            found_reg      <= 1'b0;
            value_out_reg  <= '0;
            status_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ret_reg    <= clr_ret_next;
            init_log2_reg  <= init_log2_next;
            rehash_reg     <= rehash_next;
            cmd_reg        <= cmd_next;
            hkey_reg       <= hkey_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            cur_h_reg      <= cur_h_next;
            cur_k_reg      <= cur_k_next;
            cur_v_reg      <= cur_v_next;
            hsh_reg        <= hsh_next;
            hacc_reg       <= hacc_next;
            hcnt_reg       <= hcnt_next;
            probe_idx_reg  <= probe_idx_next;
            probe_cnt_reg  <= probe_cnt_next;
            tgt_reg        <= tgt_next;
            tfree_reg      <= tfree_next;
            have_reg       <= have_next;
            clr_idx_reg    <= clr_idx_next;
            scan_idx_reg   <= scan_idx_next;
            old_log2_reg   <= old_log2_next;
            log2_reg       <= log2_next;
            live_reg       <= live_next;
            used_reg       <= used_next;
            op_reg         <= op_next;
            bank_reg       <= bank_next;
            src_bank_reg   <= src_bank_next;
            in_rebuild_reg <= in_rebuild_next;
            then_cmd_reg   <= then_cmd_next;
            found_reg      <= found_next;
            value_out_reg  <= value_out_next;
            status_reg     <= status_next;
        end
    end

`ifndef SYNTHESIS
    a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("live entries exceed used slots");

    a_used_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= size)
        else $error("used slots exceed table size");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
`endif

endmodule
